[hdl/shelf_rectangle_packer_core_macros.svh]
// ----------------------------------------------------------------------------
// shelf rectangle packer assertion macros
// concurrent assertion shorthands shared by the checker
// ----------------------------------------------------------------------------
`ifndef SHELF_RECTANGLE_PACKER_CORE_MACROS_SVH
`define SHELF_RECTANGLE_PACKER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define SRP_ASSERT_SAME(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define SRP_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

[hdl/srp_pkg.sv]
// ----------------------------------------------------------------------------
// srp_pkg
// types, constants and helpers of the shelf rectangle packer
// ----------------------------------------------------------------------------
package srp_pkg;

  localparam int MAX_SIDE  = 4096;
  localparam int MAX_COUNT = 4095;

  localparam int SIDE_W  = 13;
  localparam int RECT_W  = 12;
  localparam int CNT_W   = 12;
  localparam int CFG_INDEX_W = 2;

  localparam logic [SIDE_W-1:0] SIDE_MAX_C  = SIDE_W'(MAX_SIDE);
  localparam logic [SIDE_W-1:0] SIDE_RESET_C = SIDE_W'(1024);
  localparam logic [CNT_W-1:0]  CNT_MAX_C   =
    CNT_W'((MAX_COUNT > 4095) ? 4095 : MAX_COUNT);

  localparam logic [CFG_INDEX_W-1:0] CFG_ATLAS_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_ATLAS_HEIGHT = CFG_INDEX_W'(1);

  typedef enum logic {
    OP_PACK  = 1'b0,
    OP_CHECK = 1'b1
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  // result of one placement step of the shared unit
  typedef struct packed {
    logic              fit;
    logic [SIDE_W-1:0] x_next;
    logic [SIDE_W-1:0] y_next;
    logic [RECT_W-1:0] rh_next;
    logic [SIDE_W-1:0] left;
    logic [SIDE_W-1:0] top;
    logic [SIDE_W-1:0] right;
    logic [SIDE_W-1:0] bottom;
  } step_t;

  // clamp a 14 bit sum to the 13 bit range
  function automatic logic [SIDE_W-1:0] sat13(input logic [SIDE_W:0] v);
    return v[SIDE_W] ? {SIDE_W{1'b1}} : v[SIDE_W-1:0];
  endfunction

endpackage

[hdl/srp_step_unit.sv]
// ----------------------------------------------------------------------------
// srp_step_unit
// one shelf placement step: row wrap, fit test and cursor advance
// ----------------------------------------------------------------------------
module srp_step_unit (
  input  logic [srp_pkg::SIDE_W-1:0] x,
  input  logic [srp_pkg::SIDE_W-1:0] y,
  input  logic [srp_pkg::RECT_W-1:0] rh,
  input  logic [srp_pkg::RECT_W-1:0] w,
  input  logic [srp_pkg::RECT_W-1:0] h,
  input  logic [srp_pkg::SIDE_W-1:0] aw,
  input  logic [srp_pkg::SIDE_W-1:0] ah,
  output srp_pkg::step_t             res
);

  logic [srp_pkg::SIDE_W:0]   x_sum;
  logic                       wrap;
  logic [srp_pkg::SIDE_W-1:0] xw;
  logic [srp_pkg::SIDE_W-1:0] yw;
  logic [srp_pkg::RECT_W-1:0] rhw;
  logic [srp_pkg::SIDE_W:0]   yh_sum;
  logic [srp_pkg::SIDE_W:0]   xw_sum;
  logic                       fit;

  always_comb begin
    x_sum  = {1'b0, x} + {2'b00, w};
    wrap   = x_sum > {1'b0, aw};
    // wrap opens a new row below the tallest rectangle of the current row
    xw     = wrap ? '0 : x;
    yw     = wrap ? srp_pkg::sat13({1'b0, y} + {2'b00, rh}) : y;
    rhw    = wrap ? '0 : rh;
    yh_sum = {1'b0, yw} + {2'b00, h};
    xw_sum = {1'b0, xw} + {2'b00, w};
    fit    = ({1'b0, w} <= aw) && (yh_sum <= {1'b0, ah});

    res.fit     = fit;
    res.x_next  = fit ? srp_pkg::sat13(xw_sum) : xw;
    res.y_next  = yw;
    res.rh_next = (fit && (h > rhw)) ? h : rhw;
    res.left    = xw;
    res.top     = yw;
    res.right   = srp_pkg::sat13(xw_sum);
    res.bottom  = srp_pkg::sat13(yh_sum);
  end

endmodule

[hdl/shelf_rectangle_packer_core.sv]
// ----------------------------------------------------------------------------
// shelf_rectangle_packer_core
// row-by-row rectangle allocator for a fixed size atlas
// ----------------------------------------------------------------------------
// Places rectangles left to right along a row; a rectangle that does not fit
// the rest of the row wraps the cursor to a new row below that row's tallest
// one. A pack item (tuser 0) returns the placed rectangle or fails, which sets
// the sticky full flag while any wrap stays committed. A check item (tuser 1)
// answers whether rect_count equal rectangles would still fit, leaving the
// state as it was. One placement step unit does all the work under a two
// state sequencer, so an item is accepted only while the sequencer is idle.
// A pack item is accepted and then placed in one step; a check item takes
// one step per rectangle and ends early on the first miss; a check with
// count zero or while full is answered without stepping. The result leaves
// through an output register, so the next item is taken while a result still
// waits; a finished item only stalls when that register is still occupied.
// Atlas size registers are written through cfg_wr_en, cfg_index and cfg_data
// (the user must do so only while no item is in flight; the block does not
// enforce it). Values above 4096 saturate, unknown indexes are ignored.
// ----------------------------------------------------------------------------
module shelf_rectangle_packer_core (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic                            cfg_wr_en,
  input  logic [srp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [srp_pkg::SIDE_W-1:0]      cfg_data,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // rect_width[11:0], rect_height[23:12], rect_count[35:24]
  input  logic        s_tuser,  // operation
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,  // left[12:0], top[25:13], right[38:26], bottom[51:39]
  output logic [1:0]  m_tuser   // success[0], atlas_full[1]
);

  // configuration
  logic [srp_pkg::SIDE_W-1:0] atlas_width;
  logic [srp_pkg::SIDE_W-1:0] atlas_height;
  logic [srp_pkg::SIDE_W-1:0] cfg_sat;

  // committed packing state
  logic [srp_pkg::SIDE_W-1:0] cursor_x;
  logic [srp_pkg::SIDE_W-1:0] cursor_y;
  logic [srp_pkg::RECT_W-1:0] row_height;
  logic                       full_flag;

  // sequencer and item registers
  srp_pkg::state_t            state;
  srp_pkg::state_t            state_next;
  srp_pkg::op_t               op;
  logic [srp_pkg::RECT_W-1:0] rect_w;
  logic [srp_pkg::RECT_W-1:0] rect_h;
  logic [srp_pkg::CNT_W-1:0]  remain;
  logic [srp_pkg::CNT_W-1:0]  in_count;
  logic                       quick;     // check answered without stepping
  logic                       quick_ok;

  // trial cursor walked by the step unit
  logic [srp_pkg::SIDE_W-1:0] trial_x;
  logic [srp_pkg::SIDE_W-1:0] trial_y;
  logic [srp_pkg::RECT_W-1:0] trial_rh;

  srp_pkg::step_t             step;

  // sequencer outputs
  logic accept;
  logic slot_free;
  logic last_step;
  logic finish;
  logic advance;
  logic res_ok;

  srp_step_unit u_step (
    .x   (trial_x),
    .y   (trial_y),
    .rh  (trial_rh),
    .w   (rect_w),
    .h   (rect_h),
    .aw  (atlas_width),
    .ah  (atlas_height),
    .res (step)
  );

  // counts above the limit clamp
  assign in_count = (s_tdata[35:24] > srp_pkg::CNT_MAX_C) ? srp_pkg::CNT_MAX_C
                                                          : s_tdata[35:24];
  assign cfg_sat  = (cfg_data > srp_pkg::SIDE_MAX_C) ? srp_pkg::SIDE_MAX_C : cfg_data;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      srp_pkg::ST_IDLE: if (s_tvalid) state_next = srp_pkg::ST_RUN;
      srp_pkg::ST_RUN:  if (finish)   state_next = srp_pkg::ST_IDLE;
      default:          state_next = srp_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready  = 1'b0;
    last_step = 1'b0;
    finish    = 1'b0;
    advance   = 1'b0;
    slot_free = !m_tvalid || m_tready;
    res_ok    = quick ? quick_ok : step.fit;
    unique case (state)
      srp_pkg::ST_IDLE: s_tready = 1'b1;
      srp_pkg::ST_RUN: begin
        // a pack is one step; a check ends on a miss, on its last rectangle or when answered without stepping
        last_step = quick || (op == srp_pkg::OP_PACK) || !step.fit ||
                    (remain == srp_pkg::CNT_W'(1));
        finish    = last_step && slot_free;
        advance   = !last_step;
      end
      default: ;
    endcase
  end

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_width  <= srp_pkg::SIDE_RESET_C;
      atlas_height <= srp_pkg::SIDE_RESET_C;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        srp_pkg::CFG_ATLAS_WIDTH:  atlas_width  <= cfg_sat;
        srp_pkg::CFG_ATLAS_HEIGHT: atlas_height <= cfg_sat;
        default: ;
      endcase
    end
  end

  // item capture and trial walk
  always_ff @(posedge clk) begin
    if (accept) begin
      op       <= srp_pkg::op_t'(s_tuser);
      rect_w   <= s_tdata[11:0];
      rect_h   <= s_tdata[23:12];
      remain   <= in_count;
      quick    <= (s_tuser == srp_pkg::OP_CHECK) && ((in_count == '0) || full_flag);
      quick_ok <= (in_count == '0);
      trial_x  <= cursor_x;
      trial_y  <= cursor_y;
      trial_rh <= row_height;
    end else if (advance) begin
      remain   <= remain - srp_pkg::CNT_W'(1);
      trial_x  <= step.x_next;
      trial_y  <= step.y_next;
      trial_rh <= step.rh_next;
    end
  end

  // committed state: only a pack writes it back, a wrap sticks even on a miss
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x   <= '0;
      cursor_y   <= '0;
      row_height <= '0;
      full_flag  <= 1'b0;
    end else if (finish && (op == srp_pkg::OP_PACK)) begin
      cursor_x   <= step.x_next;
      cursor_y   <= step.y_next;
      row_height <= step.rh_next;
      full_flag  <= full_flag || !step.fit;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if ((op == srp_pkg::OP_PACK) && step.fit) begin
        m_tdata <= {4'b0000, step.bottom, step.right, step.top, step.left};
      end else begin
        m_tdata <= '0;
      end
      m_tuser[0] <= res_ok;
      m_tuser[1] <= (op == srp_pkg::OP_PACK) ? (full_flag || !step.fit) : full_flag;
    end
  end

endmodule

[hdl/srp_checker.sv]
// ----------------------------------------------------------------------------
// srp_checker
// port level checks of the shelf rectangle packer
// ----------------------------------------------------------------------------
`include "shelf_rectangle_packer_core_macros.svh"

module srp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic [1:0]  m_tuser
);

  logic full_seen;

  // full flag seen on a delivered item
  always_ff @(posedge clk) begin
    if (rst) begin
      full_seen <= 1'b0;
    end else if (m_tvalid && m_tready && m_tuser[1]) begin
      full_seen <= 1'b1;
    end
  end

  `SRP_ASSERT_NEXT(a_in_busy, s_tvalid && s_tready, !s_tready, "input taken while an item is in work")
  `SRP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result item changed")
  `SRP_ASSERT_SAME(a_full_sticky, m_tvalid && full_seen, m_tuser[1], "atlas full flag cleared")
  `SRP_ASSERT_SAME(a_fail_zero, m_tvalid && !m_tuser[0], m_tdata == '0, "failed item carries coordinates")
  `SRP_ASSERT_SAME(a_rect_order, m_tvalid, (m_tdata[38:26] >= m_tdata[12:0]) && (m_tdata[51:39] >= m_tdata[25:13]), "rectangle corners out of order")

endmodule

bind shelf_rectangle_packer_core srp_checker u_srp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
